@@ rtl/lhm_pkg.sv @@
package lhm_pkg;

    localparam int LETTERS     = 26;
    localparam int IDX_W       = 5;
    localparam int BYTE_W      = 8;
    localparam int TOP_COUNT_W = 16;

    localparam logic [BYTE_W-1:0] TERM_BYTE   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'd32;

    typedef struct packed {
        logic             term;
        logic             letter;
        logic [IDX_W-1:0] idx;
    } lhm_class_t;

endpackage

@@ rtl/lhm_classify.sv @@
module lhm_classify (
    input  logic [7:0]          text_byte,
    output lhm_pkg::lhm_class_t cls
);
    import lhm_pkg::*;

    logic [BYTE_W-1:0] folded;
    logic [BYTE_W-1:0] offset;

    always_comb
    begin
        // fold upper case onto lower case
        if (text_byte >= CHAR_UPPER_A && text_byte <= CHAR_UPPER_Z)
        begin
            folded = text_byte + CASE_OFFSET;
        end
        else
        begin
            folded = text_byte;
        end
        offset     = folded - CHAR_LOWER_A;
        cls.term   = (text_byte == TERM_BYTE);
        cls.letter = (folded >= CHAR_LOWER_A) && (folded <= CHAR_LOWER_Z);
        cls.idx    = offset[IDX_W-1:0];
    end

endmodule

@@ rtl/lhm_tally.sv @@
module lhm_tally #(
    parameter longint unsigned COUNT_MAX = 65535,
    parameter int              CNT_W     = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  lhm_pkg::lhm_class_t       cls,
    output logic [lhm_pkg::IDX_W-1:0] best_letter,
    output logic [CNT_W-1:0]          best_count
);
    import lhm_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(COUNT_MAX);

    logic [CNT_W-1:0] cnt_reg [LETTERS];
    logic [CNT_W-1:0] best_count_reg;
    logic [IDX_W-1:0] best_letter_reg;

    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] cnt_next;
    logic             bump;
    logic             take_best;

    always_comb
    begin
        cur      = cnt_reg[cls.idx];
        cnt_next = cur + CNT_W'(1);
        bump     = step && cls.letter && (cur < CNT_LIMIT);
        // earlier letter wins a tie
        take_best = bump && ((cnt_next > best_count_reg) ||
                    ((cnt_next == best_count_reg) && (cls.idx < best_letter_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LETTERS; k++)
            begin
                cnt_reg[k] <= '0;
            end
            best_count_reg  <= '0;
            best_letter_reg <= '0;
        end
        else if (step && cls.term)
        begin
            // string done: start the next one fresh
            for (int k = 0; k < LETTERS; k++)
            begin
                cnt_reg[k] <= '0;
            end
            best_count_reg  <= '0;
            best_letter_reg <= '0;
        end
        else
        begin
            if (bump)
            begin
                cnt_reg[cls.idx] <= cnt_next;
            end
            if (take_best)
            begin
                best_count_reg  <= cnt_next;
                best_letter_reg <= cls.idx;
            end
        end
    end

    assign best_letter = best_letter_reg;
    assign best_count  = best_count_reg;

    a_best_limit: assert property (@(posedge clk) disable iff (!rst_n)
        best_count_reg <= CNT_LIMIT)
        else $error("running best count above counter limit");

    a_best_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
        best_letter_reg < IDX_W'(LETTERS))
        else $error("running best letter out of range");

    a_clear_on_term: assert property (@(posedge clk) disable iff (!rst_n)
        step && cls.term |=> (best_count_reg == '0) && (best_letter_reg == '0))
        else $error("running best not cleared after terminator");

endmodule

@@ rtl/letter_histogram_mode.sv @@
// Case-insensitive letter frequency mode. One text byte is taken per request,
// one per cycle sustained; a zero byte ends the string and yields one result
// (most frequent letter, its count, and whether any letter was seen), after
// which all counters clear for the next string. Other bytes yield nothing.
// Each byte passes an input register, then the counter update and running-best
// compare; a terminator's result is registered into the output register once
// the result slot is free. Input stalls only while a result sits unread.
module letter_histogram_mode #(
    parameter longint unsigned COUNT_MAX = 65535
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      text_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [4:0]                      top_letter,
    output logic [lhm_pkg::TOP_COUNT_W-1:0] top_count,
    output logic                            letter_seen
);
    import lhm_pkg::*;

    localparam int CNT_W = $clog2(COUNT_MAX + 64'd1);

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;

    logic                   out_valid_reg;
    logic [IDX_W-1:0]       top_letter_reg;
    logic [TOP_COUNT_W-1:0] top_count_reg;
    logic                   letter_seen_reg;

    lhm_class_t       cls;
    logic [IDX_W-1:0] best_letter;
    logic [CNT_W-1:0] best_count;
    logic [63:0]      best_wide;
    logic             out_free;
    logic             s1_advance;
    logic             emit;

    lhm_classify u_classify (
        .text_byte (s1_byte_reg),
        .cls       (cls)
    );

    lhm_tally #(
        .COUNT_MAX (COUNT_MAX),
        .CNT_W     (CNT_W)
    ) u_tally (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_advance),
        .cls         (cls),
        .best_letter (best_letter),
        .best_count  (best_count)
    );

    always_comb
    begin
        best_wide  = 64'(best_count);
        out_free   = !out_valid_reg || out_ready;
        // hold a terminator until the result slot can take it
        s1_advance = s1_valid_reg && (!cls.term || out_free);
        emit       = s1_advance && cls.term;
        in_ready   = !s1_valid_reg || s1_advance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= text_byte;
        end
        if (emit)
        begin
            top_letter_reg  <= best_letter;
            top_count_reg   <= best_wide[TOP_COUNT_W-1:0];
            letter_seen_reg <= (best_count != '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign top_letter  = top_letter_reg;
    assign top_count   = top_count_reg;
    assign letter_seen = letter_seen_reg;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && cls.term && out_valid_reg)
        else $error("input stalled without a blocked terminator");

    a_no_letter_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !letter_seen_reg |-> top_letter_reg == '0)
        else $error("letter reported for a string without letters");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("terminator did not produce a result");

endmodule
